// ===== design/c8cfr_pkg.sv =====
// shared types, constants and codes of the crc-8 command frame receiver
`default_nettype none
package c8cfr_pkg;

   localparam int FRAME_BYTES = 6;
   localparam int POS_W = 3;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
   localparam logic [POS_W-1:0] ADDR_POS = POS_W'(2);
   localparam logic [POS_W-1:0] CMD_POS = POS_W'(3);
   localparam logic [POS_W-1:0] HUNT_POS = POS_W'(0);

   localparam logic [7:0] CRC_POLY = 8'h1D;

   localparam logic [7:0] SYNC_BYTE_RESET = 8'h7E;
   localparam logic [7:0] NODE_ADDRESS_RESET = 8'h04;
   localparam logic [7:0] CRC_PRESET_RESET = 8'hFF;

   typedef enum logic [1:0] {
      CSR_SYNC_BYTE    = 2'd0,
      CSR_NODE_ADDRESS = 2'd1,
      CSR_CRC_PRESET   = 2'd2
   } csr_index_type;

   typedef enum logic [7:0] {
      CMD_BACK    = 8'h00,
      CMD_RIGHT   = 8'h01,
      CMD_LEFT    = 8'h02,
      CMD_FORWARD = 8'h03,
      CMD_STOP    = 8'h04
   } command_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_BACK    = 3'd1,
      ACT_RIGHT   = 3'd2,
      ACT_LEFT    = 3'd3,
      ACT_FORWARD = 3'd4,
      ACT_STOP    = 3'd5
   } action_type;

   typedef struct packed {
      logic [7:0] sync_byte;
      logic [7:0] node_address;
      logic [7:0] crc_preset;
   } cfg_type;

   typedef struct packed {
      logic       frame_done;
      logic       crc_ok;
      logic       for_this_node;
      action_type action;
   } result_type;

endpackage
`default_nettype wire

// ===== design/c8cfr_req_if.sv =====
// input byte channel of the frame receiver
`default_nettype none
interface c8cfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== design/c8cfr_rsp_if.sv =====
// result channel of the frame receiver
`default_nettype none
interface c8cfr_rsp_if;
   logic       valid;
   logic       ready;
   logic       frame_done;
   logic       crc_ok;
   logic       for_this_node;
   logic [2:0] action;

   modport source (output valid, output frame_done, output crc_ok, output for_this_node,
                   output action, input ready);
   modport sink (input valid, input frame_done, input crc_ok, input for_this_node,
                 input action, output ready);
endinterface
`default_nettype wire

// ===== design/c8cfr_csr.sv =====
// configuration registers of the frame receiver
`default_nettype none
module c8cfr_csr (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [1:0]           csr_index,
   input  wire logic [7:0]           csr_wdata,
   output c8cfr_pkg::cfg_type        cfg
);

   c8cfr_pkg::cfg_type cfg_ff;
   c8cfr_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (c8cfr_pkg::csr_index_type'(csr_index))
            c8cfr_pkg::CSR_SYNC_BYTE:    cfg_in.sync_byte = csr_wdata;
            c8cfr_pkg::CSR_NODE_ADDRESS: cfg_in.node_address = csr_wdata;
            c8cfr_pkg::CSR_CRC_PRESET:   cfg_in.crc_preset = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_byte    <= c8cfr_pkg::SYNC_BYTE_RESET;
         cfg_ff.node_address <= c8cfr_pkg::NODE_ADDRESS_RESET;
         cfg_ff.crc_preset   <= c8cfr_pkg::CRC_PRESET_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== design/c8cfr_crc.sv =====
// one-byte msb-first crc-8 update, unrolled over the eight bits
`default_nettype none
module c8cfr_crc (
   input  wire logic [7:0] crc_cur,
   input  wire logic [7:0] data,
   output logic      [7:0] crc_next
);

   always_comb begin
      logic [7:0] c;
      c = crc_cur ^ data;
      for (int b = 0; b < 8; b++) begin
         if (c[7]) c = {c[6:0], 1'b0} ^ c8cfr_pkg::CRC_POLY;
         else      c = {c[6:0], 1'b0};
      end
      crc_next = c;
   end

endmodule
`default_nettype wire

// ===== design/c8cfr_frame.sv =====
// frame tracking state, check and decode, and the result register
`default_nettype none
module c8cfr_frame (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire c8cfr_pkg::cfg_type    cfg,
   input  wire logic                  in_valid,
   input  wire logic [7:0]            in_byte,
   output logic                       in_ready,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output c8cfr_pkg::result_type      out_result
);

   logic [c8cfr_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] addr_ff, addr_in;
   logic [7:0] cmd_ff, cmd_in;
   logic       valid_ff, valid_in;
   c8cfr_pkg::result_type result_ff, result_in;

   logic       accept;
   logic [7:0] crc_seed;
   logic [7:0] crc_next;
   c8cfr_pkg::action_type decoded;

   assign in_ready = !valid_ff || out_ready;
   assign accept = in_valid && in_ready;

   // the sync byte starts from the preset, later bytes from the running crc
   assign crc_seed = (pos_ff == c8cfr_pkg::HUNT_POS) ? cfg.crc_preset : crc_ff;

   c8cfr_crc u_crc (
      .crc_cur  (crc_seed),
      .data     (in_byte),
      .crc_next (crc_next)
   );

   always_comb begin
      unique case (c8cfr_pkg::command_type'(cmd_ff))
         c8cfr_pkg::CMD_BACK:    decoded = c8cfr_pkg::ACT_BACK;
         c8cfr_pkg::CMD_RIGHT:   decoded = c8cfr_pkg::ACT_RIGHT;
         c8cfr_pkg::CMD_LEFT:    decoded = c8cfr_pkg::ACT_LEFT;
         c8cfr_pkg::CMD_FORWARD: decoded = c8cfr_pkg::ACT_FORWARD;
         c8cfr_pkg::CMD_STOP:    decoded = c8cfr_pkg::ACT_STOP;
         default:                decoded = c8cfr_pkg::ACT_NONE;
      endcase
   end

   always_comb begin
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      addr_in   = addr_ff;
      cmd_in    = cmd_ff;
      result_in = result_ff;
      valid_in  = valid_ff;
      if (out_ready) valid_in = 1'b0;
      if (accept) begin
         valid_in = 1'b1;
         result_in.frame_done    = 1'b0;
         result_in.crc_ok        = 1'b0;
         result_in.for_this_node = 1'b0;
         result_in.action        = c8cfr_pkg::ACT_NONE;
         if (pos_ff == c8cfr_pkg::HUNT_POS) begin
            if (in_byte == cfg.sync_byte) begin
               crc_in  = crc_next;
               addr_in = 8'h00;
               cmd_in  = 8'h00;
               pos_in  = c8cfr_pkg::POS_W'(1);
            end
         end else if (pos_ff >= c8cfr_pkg::LAST_POS) begin
            // check byte
            result_in.frame_done    = 1'b1;
            result_in.crc_ok        = (crc_ff == in_byte);
            result_in.for_this_node = (addr_ff == cfg.node_address);
            if ((crc_ff == in_byte) && (addr_ff == cfg.node_address))
               result_in.action = decoded;
            pos_in = c8cfr_pkg::HUNT_POS;
         end else begin
            if (pos_ff == c8cfr_pkg::ADDR_POS) addr_in = in_byte;
            if (pos_ff == c8cfr_pkg::CMD_POS) cmd_in = in_byte;
            crc_in = crc_next;
            pos_in = pos_ff + c8cfr_pkg::POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= c8cfr_pkg::HUNT_POS;
         crc_ff   <= c8cfr_pkg::CRC_PRESET_RESET;
         addr_ff  <= 8'h00;
         cmd_ff   <= 8'h00;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
         addr_ff  <= addr_in;
         cmd_ff   <= cmd_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule
`default_nettype wire

// ===== design/crc8_command_frame_receiver.sv =====
// top level of the crc-8 command frame receiver
// Usage:
//   req_bus carries one received byte per beat. The block hunts for the sync
//   byte, then collects a frame of FRAME_BYTES bytes; the running crc-8
//   (poly 0x1d, msb first, preset from csr) covers all but the last byte,
//   which is the check byte.
//   rsp_bus returns exactly one result beat for every request beat: frame_done,
//   crc_ok, for_this_node and action are all zero unless that byte closed a
//   frame. The action is decoded only for a frame with good crc and our address.
//   The result beat is registered and offered the cycle after its request beat;
//   throughput is one byte per cycle unless rsp_bus stalls, set by the
//   combinational unrolled crc update between the frame state and result registers.
//   req_bus.ready is high while the result register is empty or being taken,
//   so a stalled receiver on rsp_bus holds one result and then stalls req_bus.
//   The csr port writes sync_byte (0), node_address (1) and crc_preset (2);
//   other indexes are ignored. Write only while idle.
//   Synchronous reset restores register defaults (0x7e, 0x04, 0xff), returns
//   to sync hunting and empties the result register.
`default_nettype none
module crc8_command_frame_receiver (
   input  wire logic       clock,
   input  wire logic       reset,
   c8cfr_req_if.sink       req_bus,
   c8cfr_rsp_if.source     rsp_bus,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   c8cfr_pkg::cfg_type    cfg;
   c8cfr_pkg::result_type result;
   logic                  in_ready;
   logic                  out_valid;

   c8cfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   c8cfr_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_bus.valid),
      .in_byte    (req_bus.rx_byte),
      .in_ready   (in_ready),
      .out_valid  (out_valid),
      .out_ready  (rsp_bus.ready),
      .out_result (result)
   );

   assign req_bus.ready         = in_ready;
   assign rsp_bus.valid         = out_valid;
   assign rsp_bus.frame_done    = result.frame_done;
   assign rsp_bus.crc_ok        = result.crc_ok;
   assign rsp_bus.for_this_node = result.for_this_node;
   assign rsp_bus.action        = result.action;

endmodule
`default_nettype wire

// ===== test/tb_crc8_command_frame_receiver.sv =====
// testbench of the crc-8 command frame receiver: framed random byte traffic against a predictor
module tb_crc8_command_frame_receiver;
   timeunit 1ns;
   timeprecision 1ps;

   import c8cfr_pkg::*;

   localparam logic [1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int HOLD_START = 300;
   localparam int HOLD_CYCLES = 500;
   localparam int STALL_LIMIT = 4000;

   class frame_verdict_board;
      cfg_type cfg;
      logic [POS_W-1:0] frame_pos;
      logic [7:0] crc_acc;
      logic [7:0] address_byte;
      logic [7:0] command_byte;
      result_type pending_verdicts[$];
      int errors;

      function new();
         cfg.sync_byte = SYNC_BYTE_RESET;
         cfg.node_address = NODE_ADDRESS_RESET;
         cfg.crc_preset = CRC_PRESET_RESET;
         frame_pos = HUNT_POS;
         crc_acc = CRC_PRESET_RESET;
         address_byte = 8'h00;
         command_byte = 8'h00;
         errors = 0;
      endfunction

      static function logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] data);
         logic [7:0] c;
         c = crc ^ data;
         for (int b = 0; b < 8; b++)
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
         return c;
      endfunction

      static function action_type decode_command(logic [7:0] cmd);
         case (cmd)
            CMD_BACK:    return ACT_BACK;
            CMD_RIGHT:   return ACT_RIGHT;
            CMD_LEFT:    return ACT_LEFT;
            CMD_FORWARD: return ACT_FORWARD;
            CMD_STOP:    return ACT_STOP;
            default:     return ACT_NONE;
         endcase
      endfunction

      function void write_reg(logic [1:0] idx, logic [7:0] value);
         case (idx)
            CSR_SYNC_BYTE:    cfg.sync_byte = value;
            CSR_NODE_ADDRESS: cfg.node_address = value;
            CSR_CRC_PRESET:   cfg.crc_preset = value;
            default: ;
         endcase
      endfunction

      function void predict_byte(logic [7:0] rx);
         result_type r;
         r = '0;
         if (frame_pos == HUNT_POS) begin
            if (rx == cfg.sync_byte) begin
               crc_acc = crc8_step(cfg.crc_preset, rx);
               address_byte = 8'h00;
               command_byte = 8'h00;
               frame_pos = POS_W'(1);
            end
         end else if (frame_pos >= LAST_POS) begin
            r.frame_done = 1'b1;
            r.crc_ok = (crc_acc == rx);
            r.for_this_node = (address_byte == cfg.node_address);
            if (r.crc_ok && r.for_this_node)
               r.action = decode_command(command_byte);
            frame_pos = HUNT_POS;
         end else begin
            if (frame_pos == ADDR_POS)
               address_byte = rx;
            if (frame_pos == CMD_POS)
               command_byte = rx;
            crc_acc = crc8_step(crc_acc, rx);
            frame_pos = frame_pos + 1'b1;
         end
         pending_verdicts.push_back(r);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $display("%0d ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_verdict(logic done, logic ok, logic mine, logic [2:0] act);
         result_type want;
         if (pending_verdicts.size() == 0) begin
            $display("%0d ns: result beat with nothing expected, actual %b %b %b %0d",
                     $time, done, ok, mine, act);
            errors++;
            return;
         end
         want = pending_verdicts.pop_front();
         compare_field("frame_done", 8'(want.frame_done), 8'(done));
         compare_field("crc_ok", 8'(want.crc_ok), 8'(ok));
         compare_field("for_this_node", 8'(want.for_this_node), 8'(mine));
         compare_field("action", 8'(want.action), 8'(act));
      endfunction

      function int pending();
         return pending_verdicts.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;
   bit         quiet_tail;
   int         stall_cycles;

   frame_verdict_board sb;

   c8cfr_req_if req_bus();
   c8cfr_rsp_if rsp_bus();

   crc8_command_frame_receiver u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // beat monitor: inputs feed the predictor, results are checked in order
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            sb.predict_byte(req_bus.rx_byte);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            sb.check_verdict(rsp_bus.frame_done, rsp_bus.crc_ok, rsp_bus.for_this_node,
                             rsp_bus.action);
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) || reset)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_crc8_command_frame_receiver: FAIL");
         $finish;
      end
   end

   // result side: random backpressure plus one long hold-off to fill the block
   initial begin : result_sink
      int cyc;
      cyc = 0;
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc == HOLD_START) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // sends the first nbytes of a frame built from the current settings
   task automatic send_frame(input logic [7:0] address, input logic [7:0] command,
                             input bit corrupt, input int nbytes);
      logic [7:0] frame_bytes [FRAME_BYTES];
      logic [7:0] crc;
      frame_bytes[0] = sb.cfg.sync_byte;
      for (int i = 1; i < FRAME_BYTES - 1; i++)
         frame_bytes[i] = 8'($urandom);
      frame_bytes[ADDR_POS] = address;
      frame_bytes[CMD_POS] = command;
      crc = sb.cfg.crc_preset;
      for (int i = 0; i < FRAME_BYTES - 1; i++)
         crc = frame_verdict_board::crc8_step(crc, frame_bytes[i]);
      frame_bytes[FRAME_BYTES-1] = corrupt ? crc ^ (8'h01 << $urandom_range(0, 7)) : crc;
      for (int i = 0; i < nbytes; i++)
         send_byte(frame_bytes[i]);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   task automatic program_regs(input logic [7:0] sync_val, input logic [7:0] node_val,
                               input logic [7:0] preset_val, input bit poke_unused);
      write_reg(CSR_SYNC_BYTE, sync_val);
      write_reg(CSR_NODE_ADDRESS, node_val);
      write_reg(CSR_CRC_PRESET, preset_val);
      if (poke_unused)
         write_reg(CSR_UNUSED_INDEX, 8'($urandom));
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic run_random(input int n_items);
      int sent;
      int pick;
      int n;
      logic [7:0] address;
      logic [7:0] command;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         address = ($urandom_range(0, 3) != 0) ? sb.cfg.node_address : 8'($urandom);
         command = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 4)) : 8'($urandom);
         if (pick < 80) begin
            send_frame(address, command, $urandom_range(0, 9) == 0, FRAME_BYTES);
            sent += FRAME_BYTES;
         end else if (pick < 90) begin
            // truncated frame, the next frame finishes it out of step
            n = $urandom_range(1, FRAME_BYTES - 1);
            send_frame(address, command, 1'b0, n);
            sent += n;
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom));
            sent += n;
         end
      end
   endtask

   initial begin : stimulus
      sb = new();
      quiet_tail = 1'b0;
      stall_cycles = 0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.rx_byte <= 8'h00;
      csr_we <= 1'b0;
      csr_index <= CSR_SYNC_BYTE;
      csr_wdata <= 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // noise while hunting, then good, bad-crc, foreign and unknown-command frames
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(NODE_ADDRESS_RESET, CMD_STOP, 1'b0, FRAME_BYTES);
      send_frame(NODE_ADDRESS_RESET, CMD_BACK, 1'b1, FRAME_BYTES);
      send_frame(8'h05, SYNC_BYTE_RESET, 1'b0, FRAME_BYTES);
      send_frame(NODE_ADDRESS_RESET, 8'h05, 1'b0, FRAME_BYTES);
      run_random(400);
      drain();

      program_regs(8'h00, 8'h00, 8'h00, 1'b1);
      run_random(350);
      drain();

      program_regs(8'hFF, 8'hFF, 8'hFF, 1'b0);
      run_random(350);
      drain();

      program_regs(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
      run_random(350);
      drain();

      quiet_tail = 1'b1;
      program_regs(SYNC_BYTE_RESET, NODE_ADDRESS_RESET, CRC_PRESET_RESET, 1'b0);
      run_random(350);
      drain();
      repeat (4) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb_crc8_command_frame_receiver: PASS");
      else
         $display("tb_crc8_command_frame_receiver: FAIL");
      $finish;
   end

endmodule
